// ----- rtl/esdr_pkg.sv -----
// Package for the encoder speed duty regulator.
// Holds the shared constants, request codes and the divider interface structs.
// No dependencies.
package esdr_pkg;

  localparam int NUM_W = 29;
  localparam logic [NUM_W-1:0] RPM_NUMER = 29'd320000000;
  localparam logic [15:0] RPM_MAX = 16'hFFFF;
  localparam logic [13:0] DUTY_FIELD_MAX = 14'h3FFF;

  localparam logic [1:0] REG_TARGET_RPM   = 2'd0;
  localparam logic [1:0] REG_ENGAGE_RPM   = 2'd1;
  localparam logic [1:0] REG_INITIAL_DUTY = 2'd2;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_EDGE = 1'b1;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] numer;
    logic [NUM_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- rtl/esdr_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on esdr_pkg for the operand width and the request structs.
module esdr_div import esdr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] num_sh;
  logic [NUM_W-1:0] denom;
  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] quot;
  logic             done;

  logic [NUM_W:0] trial;
  logic           ge;
  logic [NUM_W:0] diff;

  assign trial = {rem, num_sh[NUM_W-1]};
  assign ge    = trial >= {1'b0, denom};
  assign diff  = trial - {1'b0, denom};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_sh <= req.numer;
      denom  <= req.denom;
      rem    <= '0;
      quot   <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[NUM_W-2:0], 1'b0};
      rem    <= ge ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
      quot   <= {quot[NUM_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

// ----- rtl/esdr_duty.sv -----
// Duty step logic: one step down or up on a fresh average above the engage speed, then floor and cap.
// Depends on esdr_pkg for field widths.
module esdr_duty import esdr_pkg::*; #(
  parameter logic [13:0] DUTY_CAP = 14'd10000
) (
  input  logic [13:0] duty,
  input  logic [15:0] average,
  input  logic [15:0] target_rpm,
  input  logic [15:0] engage_rpm,
  output logic [13:0] duty_next,
  output logic        adjusted
);

  logic [14:0] dec;
  logic [14:0] inc;
  logic [14:0] stepped;

  always_comb begin
    dec       = (duty > 14'd1) ? {1'b0, duty - 14'd1} : 15'd1;
    inc       = {1'b0, duty} + 15'd1;
    stepped   = (average > target_rpm) ? dec : inc;
    adjusted  = average > engage_rpm;
    duty_next = duty;
    if (adjusted) begin
      duty_next = (stepped > {1'b0, DUTY_CAP}) ? DUTY_CAP : stepped[13:0];
    end
  end

endmodule

// ----- rtl/encoder_speed_duty_regulator.sv -----
// Encoder speed duty regulator, top level: sequencer, state and output register.
// Depends on esdr_pkg, esdr_div and esdr_duty.
//
// channel  | direction | handshake             | payload
// s_axis   | in        | tvalid/tready         | tuser: req_type; tdata: counter_value
// m_axis   | out       | tvalid/tready         | tdata: duty, speed_rpm, average_rpm, adjusted
// cfg      | in        | cfg_we, no wait       | cfg_index, cfg_data
//
// A wrap tick steps through PREP and EMIT; an edge through PREP, SCALE, CHECK,
// RPM_DIV, POST and EMIT, adding AVG_MUL and AVG_STEP when it closes an average.
// An edge whose period is not positive or too long for a nonzero speed skips RPM_DIV.
// The average uses a reciprocal multiply.
// Synchronous reset loads the register defaults and clears the period count.
// The input stays not ready while an item is in work; a held result only stalls
// the sequencer at the output register.
module encoder_speed_duty_regulator import esdr_pkg::*; #(
  parameter int SAMPLES_PER_AVERAGE = 5,
  parameter int PWM_PERIOD          = 10000,
  parameter int COUNTER_WRAP        = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic        s_axis_tuser,   // [0] req_type
  input  logic [15:0] s_axis_tdata,   // [15:0] counter_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [13:0] duty, [29:14] speed_rpm, [45:30] average_rpm, [46] adjusted, [47] zero
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [13:0] DUTY_CAP = (PWM_PERIOD > 16383) ? DUTY_FIELD_MAX :
                                     14'(PWM_PERIOD);
  localparam logic [4:0]  SAMPLES  = 5'(SAMPLES_PER_AVERAGE);
  localparam logic signed [33:0] WRAP      = 34'(COUNTER_WRAP);
  localparam logic signed [33:0] TRACK_SAT = 34'sd4294967295;
  localparam int          AVG_SHIFT = 20 + $clog2(SAMPLES_PER_AVERAGE);
  localparam logic [21:0] AVG_RECIP = 22'(((1 << AVG_SHIFT) + SAMPLES_PER_AVERAGE - 1) /
                                          SAMPLES_PER_AVERAGE);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PREP     = 4'd1;
  localparam logic [3:0] S_SCALE    = 4'd2;
  localparam logic [3:0] S_CHECK    = 4'd3;
  localparam logic [3:0] S_RPM_DIV  = 4'd4;
  localparam logic [3:0] S_POST     = 4'd5;
  localparam logic [3:0] S_AVG_MUL  = 4'd6;
  localparam logic [3:0] S_EMIT     = 4'd7;
  localparam logic [3:0] S_AVG_STEP = 4'd8;

  logic [3:0]         state;
  logic               req;
  logic [15:0]        cv;
  logic signed [32:0] track;
  logic signed [33:0] period;
  logic [35:0]        scaled;
  logic [15:0]        rpm;
  logic [19:0]        rpm_sum;
  logic [19:0]        avg_sum;
  logic [3:0]         sample_count;
  logic [13:0]        duty_value;
  logic [15:0]        last_rpm;
  logic [15:0]        last_average;
  logic               adjusted;
  logic [15:0]        target_rpm;
  logic [15:0]        engage_rpm;

  logic signed [33:0] track_sum;
  logic [19:0]        sum_inc;
  logic [3:0]         cnt_inc;
  logic               avg_close;
  logic [41:0]        avg_prod;
  logic [41:0]        avg_quot;
  logic               period_pos;
  logic               out_free;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic [13:0]        duty_next;
  logic               duty_adj;

  assign s_axis_tready = (state == S_IDLE);
  assign track_sum     = {track[32], track} + WRAP;
  assign sum_inc       = rpm_sum + {4'b0, rpm};
  assign cnt_inc       = sample_count + 4'd1;
  assign avg_close     = {1'b0, cnt_inc} >= SAMPLES;
  assign avg_prod      = {22'b0, avg_sum} * {20'b0, AVG_RECIP};
  assign avg_quot      = avg_prod >> AVG_SHIFT;
  assign period_pos    = !period[33] && (period != '0);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    div_req.start = 1'b0;
    div_req.numer = RPM_NUMER;
    div_req.denom = scaled[NUM_W-1:0];
    if (state == S_CHECK) begin
      div_req.start = period_pos && (scaled <= 36'(RPM_NUMER));
    end
  end

  esdr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  esdr_duty #(
    .DUTY_CAP (DUTY_CAP)
  ) u_duty (
    .duty       (duty_value),
    .average    (last_average),
    .target_rpm (target_rpm),
    .engage_rpm (engage_rpm),
    .duty_next  (duty_next),
    .adjusted   (duty_adj)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      track         <= '0;
      rpm_sum       <= '0;
      sample_count  <= '0;
      duty_value    <= 14'd3333;
      last_rpm      <= '0;
      last_average  <= '0;
      adjusted      <= 1'b0;
      target_rpm    <= 16'd900;
      engage_rpm    <= 16'd600;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready && state != S_EMIT) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TARGET_RPM:   target_rpm <= cfg_data;
          REG_ENGAGE_RPM:   engage_rpm <= cfg_data;
          REG_INITIAL_DUTY: duty_value <= cfg_data[13:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            req   <= s_axis_tuser;
            cv    <= s_axis_tdata;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          adjusted <= 1'b0;
          if (req == REQ_TICK) begin
            track <= (track_sum > TRACK_SAT) ? 33'h0_FFFF_FFFF : track_sum[32:0];
            state <= S_EMIT;
          end else begin
            period <= {track[32], track} + $signed({18'b0, cv});
            track  <= -$signed({17'b0, cv});
            state  <= S_SCALE;
          end
        end
        S_SCALE: begin
          scaled <= {1'b0, period[32:0], 2'b0} + {2'b0, period[32:0], 1'b0};
          state  <= S_CHECK;
        end
        S_CHECK: begin
          if (!period_pos) begin
            rpm   <= RPM_MAX;
            state <= S_POST;
          end else if (scaled > 36'(RPM_NUMER)) begin
            rpm   <= '0;
            state <= S_POST;
          end else begin
            state <= S_RPM_DIV;
          end
        end
        S_RPM_DIV: begin
          if (div_rsp.done) begin
            rpm   <= (div_rsp.quot > NUM_W'(RPM_MAX)) ? RPM_MAX : div_rsp.quot[15:0];
            state <= S_POST;
          end
        end
        S_POST: begin
          last_rpm <= rpm;
          if (avg_close) begin
            avg_sum      <= sum_inc;
            rpm_sum      <= '0;
            sample_count <= '0;
            state        <= S_AVG_MUL;
          end else begin
            rpm_sum      <= sum_inc;
            sample_count <= cnt_inc;
            state        <= S_EMIT;
          end
        end
        S_AVG_MUL: begin
          last_average <= avg_quot[15:0];
          state        <= S_AVG_STEP;
        end
        S_AVG_STEP: begin
          duty_value <= duty_next;
          adjusted   <= duty_adj;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {1'b0, adjusted, last_average, last_rpm, duty_value};
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
